/* hdl/tgc_pkg.sv */
// Shared types, codes and constants of the touch gesture classifier.
package tgc_pkg;

  localparam int TGC_SLOT_COUNT = 10;

  localparam int COORD_W = 16;
  localparam int OP_W    = 3;
  localparam int SLOT_W  = 4;
  localparam int DIR_W   = 3;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 5;
  localparam int REG_W   = 3;

  // Event opcodes
  localparam logic [OP_W-1:0] OP_DOWN   = 3'd0;
  localparam logic [OP_W-1:0] OP_UP     = 3'd1;
  localparam logic [OP_W-1:0] OP_MOTION = 3'd2;
  localparam logic [OP_W-1:0] OP_CANCEL = 3'd3;
  localparam logic [OP_W-1:0] OP_EVAL   = 3'd4;

  // Directions
  localparam logic [DIR_W-1:0] SWIPE_NONE   = 3'd0;
  localparam logic [DIR_W-1:0] SWIPE_TOP    = 3'd1;
  localparam logic [DIR_W-1:0] SWIPE_RIGHT  = 3'd2;
  localparam logic [DIR_W-1:0] SWIPE_BOTTOM = 3'd3;
  localparam logic [DIR_W-1:0] SWIPE_LEFT   = 3'd4;
  localparam int               DIR_NUM      = 5;

  // Gesture kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BORDER = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [REG_W-1:0] REG_EDGE_LEFT   = 3'd0;
  localparam logic [REG_W-1:0] REG_EDGE_RIGHT  = 3'd1;
  localparam logic [REG_W-1:0] REG_EDGE_TOP    = 3'd2;
  localparam logic [REG_W-1:0] REG_EDGE_BOTTOM = 3'd3;
  localparam logic [REG_W-1:0] REG_MIN_TRAVEL  = 3'd4;

  localparam logic [COORD_W-1:0] RST_EDGE_LEFT   = 16'd0;
  localparam logic [COORD_W-1:0] RST_EDGE_RIGHT  = 16'd65535;
  localparam logic [COORD_W-1:0] RST_EDGE_TOP    = 16'd0;
  localparam logic [COORD_W-1:0] RST_EDGE_BOTTOM = 16'd65535;
  localparam logic [COORD_W-1:0] RST_MIN_TRAVEL  = 16'd160;

  // Start and end point of one slot
  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } tgc_pts_t;

  // Slot update request
  typedef struct packed {
    logic               en;
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } tgc_wr_t;

  // Slot flag summary
  typedef struct packed {
    logic down_any;
    logic ready_any;
    logic rd_ready;
  } tgc_flags_t;

endpackage

/* hdl/tgc_slot_file.sv */
// Touch slot storage: points, down and ready flags, one read port.
module tgc_slot_file import tgc_pkg::*; #(
  parameter  int SLOT_COUNT = TGC_SLOT_COUNT,
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tgc_wr_t          wr_i,
  input  logic             clr_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output tgc_pts_t         rd_pts_o,
  output tgc_flags_t       flags_o
);

  tgc_pts_t               pts_r  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  down_r;
  logic [SLOT_COUNT-1:0]  ready_r;
  logic [IDX_W-1:0]       wr_idx;

  assign wr_idx = wr_i.slot[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        pts_r[i] <= '0;
      end
      down_r  <= '0;
      ready_r <= '0;
    end else begin
      if (wr_i.en) begin
        unique case (wr_i.op)
          OP_DOWN: begin
            pts_r[wr_idx] <= '{sx: wr_i.x, sy: wr_i.y, ex: wr_i.x, ey: wr_i.y};
            down_r[wr_idx] <= 1'b1;
          end
          OP_UP: begin
            ready_r[wr_idx] <= 1'b1;
            down_r[wr_idx]  <= 1'b0;
          end
          OP_MOTION: begin
            pts_r[wr_idx].ex <= wr_i.x;
            pts_r[wr_idx].ey <= wr_i.y;
          end
          default: begin
          end
        endcase
      end
      // drop the ready flag of the slot just collected
      if (clr_en_i) begin
        ready_r[rd_idx_i] <= 1'b0;
      end
    end
  end

  assign rd_pts_o          = pts_r[rd_idx_i];
  assign flags_o.down_any  = |down_r;
  assign flags_o.ready_any = |ready_r;
  assign flags_o.rd_ready  = ready_r[rd_idx_i];

endmodule

/* hdl/tgc_arith.sv */
// Shared arithmetic unit: octant vote, travel magnitudes, registered squarer.
module tgc_arith import tgc_pkg::*; (
  input  logic                 clk,
  input  tgc_pts_t             pts_i,
  input  logic [COORD_W-1:0]   mag_i,
  output logic [DIR_W-1:0]     vote_o,
  output logic [COORD_W-1:0]   mag_dx_o,
  output logic [COORD_W-1:0]   mag_dy_o,
  output logic [2*COORD_W-1:0] sq_o
);

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] up;
  logic signed [COORD_W:0] ndx;
  logic signed [COORD_W:0] nup;
  logic [2*COORD_W-1:0]    sq_r;

  assign dx  = $signed({1'b0, pts_i.ex}) - $signed({1'b0, pts_i.sx});
  assign up  = $signed({1'b0, pts_i.sy}) - $signed({1'b0, pts_i.ey});
  assign ndx = -dx;
  assign nup = -up;

  assign mag_dx_o = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
  assign mag_dy_o = up[COORD_W] ? nup[COORD_W-1:0] : up[COORD_W-1:0];

  // screen convention: up is positive when the finger moved toward the top
  always_comb begin
    if (dx == 0 && up == 0) begin
      vote_o = SWIPE_NONE;
    end else if (up > 0 && nup <= dx && dx < up) begin
      vote_o = SWIPE_TOP;
    end else if (up < 0 && up < dx && dx <= nup) begin
      vote_o = SWIPE_BOTTOM;
    end else if ((up >= 0 && ndx > up) || (up < 0 && ndx >= nup)) begin
      vote_o = SWIPE_LEFT;
    end else begin
      vote_o = SWIPE_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= mag_i * mag_i;
  end

  assign sq_o = sq_r;

endmodule

/* hdl/touch_gesture_classifier_unit.sv */
// Top level of the touch gesture classifier: event sequencer and stream ports.
//
//  channel | direction | handshake          | content
//  --------+-----------+--------------------+-----------------------------------
//  in_     | slave     | in_tvalid/tready   | one touch event per beat
//  out_    | master    | out_tvalid/tready  | one result per input beat
//  cfg_    | slave     | cfg_valid/ready    | edge limits and minimum travel
//
//  Down, up, motion and cancel are accepted, then loaded into the output register.
//  A skipped evaluate does the same; otherwise evaluate walks the slots and decides a
//  tap or movement, and for a single finger squares the travel on the shared squarer.
//  Reset is synchronous on rst_n: flags and points clear, registers return to defaults.
//  A result waits in the sequencer while the output register is full; no beat is
//  accepted until it moves on. cfg_ready is always high.
module touch_gesture_classifier_unit import tgc_pkg::*; #(
  parameter  int SLOT_COUNT = TGC_SLOT_COUNT,
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,   // slot[3:0], pos_x[19:4], pos_y[35:20], zero pad
  input  logic [OP_W-1:0]    in_tuser,   // opcode[2:0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // direction[2:0], finger_count[7:3]
  output logic [2:0]         out_tuser,  // gesture_valid[0], gesture_kind[2:1]
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SQX    = 3'd3;
  localparam logic [2:0] S_SQY    = 3'd4;
  localparam logic [2:0] S_SQL    = 3'd5;
  localparam logic [2:0] S_CMP    = 3'd6;
  localparam logic [2:0] S_WRITE  = 3'd7;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // unpack the event beat
  logic [OP_W-1:0]    in_op;
  logic [SLOT_W-1:0]  in_slot;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic               in_acc;
  logic               slot_ok;

  assign in_op   = in_tuser;
  assign in_slot = in_tdata[3:0];
  assign in_x    = in_tdata[19:4];
  assign in_y    = in_tdata[35:20];
  assign in_acc  = in_tvalid && in_tready;
  assign slot_ok = {1'b0, in_slot} < (SLOT_W+1)'(SLOT_COUNT);

  // configuration registers
  logic [COORD_W-1:0] edge_left_r, edge_right_r, edge_top_r, edge_bottom_r, min_travel_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_left_r   <= RST_EDGE_LEFT;
      edge_right_r  <= RST_EDGE_RIGHT;
      edge_top_r    <= RST_EDGE_TOP;
      edge_bottom_r <= RST_EDGE_BOTTOM;
      min_travel_r  <= RST_MIN_TRAVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EDGE_LEFT:   edge_left_r   <= cfg_data;
        REG_EDGE_RIGHT:  edge_right_r  <= cfg_data;
        REG_EDGE_TOP:    edge_top_r    <= cfg_data;
        REG_EDGE_BOTTOM: edge_bottom_r <= cfg_data;
        REG_MIN_TRAVEL:  min_travel_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  logic [2:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     last_r, last_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     votes_r [DIR_NUM];
  logic [CNT_W-1:0]     votes_nxt [DIR_NUM];
  logic [DIR_W-1:0]     dir_r, dir_nxt;
  logic [2*COORD_W:0]   acc_r, acc_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic [KIND_W-1:0]    res_kind_r, res_kind_nxt;
  logic [DIR_W-1:0]     res_dir_r, res_dir_nxt;
  logic [CNT_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 out_gv_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [DIR_W-1:0]     out_dir_r;
  logic [CNT_W-1:0]     out_cnt_r;

  // datapath links
  tgc_wr_t              wr;
  logic                 clr_en;
  logic [IDX_W-1:0]     rd_idx;
  tgc_pts_t             rd_pts;
  tgc_flags_t           flags;
  logic [DIR_W-1:0]     vote;
  logic [COORD_W-1:0]   mag_dx;
  logic [COORD_W-1:0]   mag_dy;
  logic [COORD_W-1:0]   sq_mag;
  logic [2*COORD_W-1:0] sq;
  logic [DIR_W-1:0]     vote_dir;
  logic [DIR_W-1:0]     edge_dir;

  assign rd_idx = (state_r == S_SCAN) ? idx_r : last_r;

  tgc_slot_file #(.SLOT_COUNT(SLOT_COUNT)) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_i     (wr),
    .clr_en_i (clr_en),
    .rd_idx_i (rd_idx),
    .rd_pts_o (rd_pts),
    .flags_o  (flags)
  );

  tgc_arith u_arith (
    .clk      (clk),
    .pts_i    (rd_pts),
    .mag_i    (sq_mag),
    .vote_o   (vote),
    .mag_dx_o (mag_dx),
    .mag_dy_o (mag_dy),
    .sq_o     (sq)
  );

  // unique largest vote count; a tie falls back to none
  always_comb begin
    logic [DIR_W-1:0] best;
    logic [CNT_W-1:0] bestn;
    logic             tie;
    best  = SWIPE_NONE;
    bestn = '0;
    tie   = 1'b0;
    for (int i = 0; i < DIR_NUM; i++) begin
      if (votes_r[i] > bestn) begin
        bestn = votes_r[i];
        best  = DIR_W'(i);
        tie   = 1'b0;
      end else if (votes_r[i] == bestn) begin
        tie = 1'b1;
      end
    end
    vote_dir = tie ? SWIPE_NONE : best;
  end

  // edge of the start point, tested left, right, top, bottom
  always_comb begin
    if (rd_pts.sx <= edge_left_r) begin
      edge_dir = SWIPE_LEFT;
    end else if (rd_pts.sx >= edge_right_r) begin
      edge_dir = SWIPE_RIGHT;
    end else if (rd_pts.sy <= edge_top_r) begin
      edge_dir = SWIPE_TOP;
    end else if (rd_pts.sy >= edge_bottom_r) begin
      edge_dir = SWIPE_BOTTOM;
    end else begin
      edge_dir = SWIPE_NONE;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_WRITE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    votes_nxt     = votes_r;
    dir_nxt       = dir_r;
    acc_nxt       = acc_r;
    res_valid_nxt = res_valid_r;
    res_kind_nxt  = res_kind_r;
    res_dir_nxt   = res_dir_r;
    res_cnt_nxt   = res_cnt_r;
    wr            = '0;
    clr_en        = 1'b0;
    sq_mag        = '0;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // default result is the empty one
          res_valid_nxt = 1'b0;
          res_kind_nxt  = KIND_NONE;
          res_dir_nxt   = SWIPE_NONE;
          res_cnt_nxt   = '0;
          state_nxt     = S_WRITE;
          if ((in_op == OP_DOWN || in_op == OP_UP || in_op == OP_MOTION) && slot_ok) begin
            wr = '{en: 1'b1, op: in_op, slot: in_slot, x: in_x, y: in_y};
          end else if (in_op == OP_EVAL && !flags.down_any && flags.ready_any) begin
            idx_nxt = '0;
            cnt_nxt = '0;
            for (int i = 0; i < DIR_NUM; i++) begin
              votes_nxt[i] = '0;
            end
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // collect one slot per cycle
        if (flags.rd_ready) begin
          clr_en          = 1'b1;
          votes_nxt[vote] = votes_r[vote] + 1'b1;
          cnt_nxt         = cnt_r + 1'b1;
          last_nxt        = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DECIDE: begin
        res_valid_nxt = 1'b1;
        res_cnt_nxt   = cnt_r;
        res_dir_nxt   = vote_dir;
        if (vote_dir == SWIPE_NONE) begin
          res_kind_nxt = KIND_TAP;
          state_nxt    = S_WRITE;
        end else if (cnt_r > CNT_W'(1)) begin
          res_kind_nxt = KIND_MOVE;
          state_nxt    = S_WRITE;
        end else begin
          dir_nxt   = vote_dir;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        sq_mag    = mag_dx;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        acc_nxt   = {1'b0, sq};
        sq_mag    = mag_dy;
        state_nxt = S_SQL;
      end
      S_SQL: begin
        acc_nxt   = acc_r + {1'b0, sq};
        sq_mag    = min_travel_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // squared travel against squared minimum, then the edge test
        if (acc_r >= {1'b0, sq} && edge_dir != SWIPE_NONE) begin
          res_kind_nxt = KIND_BORDER;
          res_dir_nxt  = edge_dir;
        end else begin
          res_kind_nxt = KIND_NONE;
          res_dir_nxt  = dir_r;
        end
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        // hold until the output register is free
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    last_r      <= last_nxt;
    cnt_r       <= cnt_nxt;
    votes_r     <= votes_nxt;
    dir_r       <= dir_nxt;
    acc_r       <= acc_nxt;
    res_valid_r <= res_valid_nxt;
    res_kind_r  <= res_kind_nxt;
    res_dir_r   <= res_dir_nxt;
    res_cnt_r   <= res_cnt_nxt;
    if (out_load) begin
      out_gv_r   <= res_valid_r;
      out_kind_r <= res_kind_r;
      out_dir_r  <= res_dir_r;
      out_cnt_r  <= res_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_dir_r};
  assign out_tuser  = {out_kind_r, out_gv_r};

endmodule

/* hdl/tgc_checker.sv */
// Port-level checker for the touch gesture classifier, bound to the top level.
module tgc_checker import tgc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[2:1] == KIND_NONE && out_tdata == 8'd0)
    else $error("empty result carries nonzero fields");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[7:3] != 5'd0)
    else $error("gesture without fingers");

  a_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == KIND_BORDER |->
      out_tdata[7:3] == 5'd1 && out_tdata[2:0] != SWIPE_NONE)
    else $error("border gesture must be one finger with an edge");

  a_tap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == KIND_TAP |-> out_tdata[2:0] == SWIPE_NONE)
    else $error("tap with a direction");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/touch_gesture_classifier_unit_checker.sv */
// Checker for the touch gesture classifier: predicts each result beat and scores the DUT.
module touch_gesture_classifier_unit_checker import tgc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [39:0]        in_tdata,   // slot[3:0], pos_x[19:4], pos_y[35:20], zero pad
  input  logic [OP_W-1:0]    in_tuser,   // opcode[2:0]
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [7:0]         out_tdata,  // direction[2:0], finger_count[7:3]
  input  logic [2:0]         out_tuser,  // gesture_valid[0], gesture_kind[2:1]
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 pending,
  output int                 gestures,
  output int                 borders
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 40;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [DIR_W-1:0]  dir;
    logic [CNT_W-1:0]  fingers;
  } gesture_t;

  // Shadow copy of the slot store and the limit registers
  tgc_pts_t                  pts [TGC_SLOT_COUNT];
  logic [TGC_SLOT_COUNT-1:0] down_m;
  logic [TGC_SLOT_COUNT-1:0] ready_m;
  logic [COORD_W-1:0]        lim_left, lim_right, lim_top, lim_bottom, travel_min;

  gesture_t expected_gestures [$];
  int       fail_count;
  int       result_count;
  int       gesture_count;
  int       border_count;

  // Direction that one finger votes for, by octant; y grows downward
  function automatic logic [DIR_W-1:0] octant_vote(tgc_pts_t p);
    int dx, up;
    dx = int'(p.ex) - int'(p.sx);
    up = int'(p.sy) - int'(p.ey);
    if (dx == 0 && up == 0) return SWIPE_NONE;
    if (up > 0 && -up <= dx && dx < up) return SWIPE_TOP;
    if (up < 0 && up < dx && dx <= -up) return SWIPE_BOTTOM;
    if (up >= 0 && -dx > up) return SWIPE_LEFT;
    if (up < 0 && -dx >= -up) return SWIPE_LEFT;
    return SWIPE_RIGHT;
  endfunction

  // Edge a long enough single swipe starts from, or none
  function automatic logic [DIR_W-1:0] swipe_edge(tgc_pts_t p);
    longint dx, dy, lim;
    dx  = longint'(p.ex) - longint'(p.sx);
    dy  = longint'(p.ey) - longint'(p.sy);
    lim = longint'(travel_min);
    if (dx * dx + dy * dy < lim * lim) return SWIPE_NONE;
    if (p.sx <= lim_left) return SWIPE_LEFT;
    if (p.sx >= lim_right) return SWIPE_RIGHT;
    if (p.sy <= lim_top) return SWIPE_TOP;
    if (p.sy >= lim_bottom) return SWIPE_BOTTOM;
    return SWIPE_NONE;
  endfunction

  // Apply one touch event to the shadow state and return the result it yields
  function automatic gesture_t step_touch_event(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                                logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    gesture_t         g;
    int               votes [DIR_NUM];
    int               fingers;
    int               lone;
    int               best_n;
    logic [DIR_W-1:0] best;
    logic [DIR_W-1:0] dir;
    logic [DIR_W-1:0] edge_dir;
    logic             tie;
    g       = '0;
    votes   = '{default: 0};
    fingers = 0;
    lone    = 0;
    best_n  = 0;
    best    = SWIPE_NONE;
    tie     = 1'b0;
    if ((op == OP_DOWN || op == OP_UP || op == OP_MOTION) && slot < TGC_SLOT_COUNT) begin
      case (op)
        OP_DOWN: begin
          pts[slot]    = '{sx: x, sy: y, ex: x, ey: y};
          down_m[slot] = 1'b1;
        end
        OP_UP: begin
          ready_m[slot] = 1'b1;
          down_m[slot]  = 1'b0;
        end
        default: begin
          pts[slot].ex = x;
          pts[slot].ey = y;
        end
      endcase
      return g;
    end
    if (op != OP_EVAL || down_m != '0) return g;
    for (int i = 0; i < TGC_SLOT_COUNT; i++) begin
      if (ready_m[i]) begin
        ready_m[i] = 1'b0;
        votes[octant_vote(pts[i])]++;
        fingers++;
        lone = i;
      end
    end
    if (fingers == 0) return g;
    // a zero count ties with the initial best, as a real tie does
    for (int d = 0; d < DIR_NUM; d++) begin
      if (votes[d] > best_n) begin
        best_n = votes[d];
        best   = DIR_W'(d);
        tie    = 1'b0;
      end else if (votes[d] == best_n) begin
        tie = 1'b1;
      end
    end
    dir = tie ? SWIPE_NONE : best;
    if (dir == SWIPE_NONE) begin
      g.kind = KIND_TAP;
    end else if (fingers > 1) begin
      g.kind = KIND_MOVE;
    end else begin
      edge_dir = swipe_edge(pts[lone]);
      if (edge_dir != SWIPE_NONE) begin
        g.kind = KIND_BORDER;
        dir    = edge_dir;
      end else begin
        g.kind = KIND_NONE;
      end
    end
    g.valid   = 1'b1;
    g.dir     = dir;
    g.fingers = CNT_W'(fingers);
    return g;
  endfunction

  always @(posedge clk) begin
    gesture_t seen;
    gesture_t want;
    if (!rst_n) begin
      for (int i = 0; i < TGC_SLOT_COUNT; i++) pts[i] = '0;
      down_m     = '0;
      ready_m    = '0;
      lim_left   = RST_EDGE_LEFT;
      lim_right  = RST_EDGE_RIGHT;
      lim_top    = RST_EDGE_TOP;
      lim_bottom = RST_EDGE_BOTTOM;
      travel_min = RST_MIN_TRAVEL;
      expected_gestures.delete();
      fail_count    = 0;
      result_count  = 0;
      gesture_count = 0;
      border_count  = 0;
    end else begin
      // score results first: a beat taken in this cycle cannot answer itself
      if (out_tvalid && out_tready) begin
        seen = '{valid: out_tuser[0], kind: out_tuser[2:1], dir: out_tdata[2:0],
                 fingers: out_tdata[7:3]};
        result_count++;
        if (expected_gestures.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"%0t: result beat %0d arrived with no prediction waiting: ",
                      "valid=%0d kind=%0d dir=%0d fingers=%0d"},
                     $time, result_count, seen.valid, seen.kind, seen.dir, seen.fingers);
        end else begin
          want = expected_gestures.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"%0t: result beat %0d: expected valid=%0d kind=%0d dir=%0d ",
                        "fingers=%0d, got valid=%0d kind=%0d dir=%0d fingers=%0d"},
                       $time, result_count, want.valid, want.kind, want.dir, want.fingers,
                       seen.valid, seen.kind, seen.dir, seen.fingers);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EDGE_LEFT:   lim_left   = cfg_data;
          REG_EDGE_RIGHT:  lim_right  = cfg_data;
          REG_EDGE_TOP:    lim_top    = cfg_data;
          REG_EDGE_BOTTOM: lim_bottom = cfg_data;
          REG_MIN_TRAVEL:  travel_min = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = step_touch_event(in_tuser, in_tdata[3:0], in_tdata[19:4], in_tdata[35:20]);
        if (want.valid) gesture_count++;
        if (want.valid && want.kind == KIND_BORDER) border_count++;
        expected_gestures.push_back(want);
      end
    end
    pending    <= expected_gestures.size();
    mismatches <= fail_count;
    gestures   <= gesture_count;
    borders    <= border_count;
  end

endmodule

/* tb/touch_gesture_classifier_unit_tb.sv */
// Testbench top for the touch gesture classifier: clock, reset, stimulus and verdict.
module touch_gesture_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgc_pkg::*;

  // Opcode with no function, used to check that the block ignores it
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  // Cycles with no beat on any channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int SEGMENTS    = 8;
  localparam int SEG_EVENTS  = 82;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [39:0]        in_tdata   = '0;
  logic [OP_W-1:0]    in_tuser   = OP_CANCEL;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic [2:0]         out_tuser;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [REG_W-1:0]   cfg_index  = REG_EDGE_LEFT;
  logic [COORD_W-1:0] cfg_data   = '0;

  int mismatches, pending, gestures, borders;

  // Stimulus shaping: percent of cycles the sender idles and the receiver stalls
  int idle_pct  = 0;
  int stall_pct = 0;

  int n_events = 0;   // every beat sent
  int n_live   = 0;   // beats the block acts on
  int n_writes = 0;
  int quiet    = 0;

  // Slots the stimulus currently holds down, so gestures can release them
  logic [TGC_SLOT_COUNT-1:0] held = '0;

  touch_gesture_classifier_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  touch_gesture_classifier_unit_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .gestures   (gestures),
    .borders    (borders)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random at the current rate, one decision per cycle
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: count cycles in which no channel moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending);
      $display("touch_gesture_classifier_unit regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // Bias positions toward both screen edges so border cases come up often
  function automatic int pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 25) return $urandom_range(300);
    if (r < 50) return $urandom_range(65535, 65235);
    return $urandom_range(65535);
  endfunction

  // Pick the next finger position: no travel, a short hop, a jump anywhere,
  // an exact axis or diagonal step (octant boundaries), or a full-width swipe
  task automatic pick_motion(input int fx, input int fy, output int tx, output int ty);
    int r, d;
    r = $urandom_range(99);
    d = $urandom_range(3000, 1);
    if (r < 12) begin
      tx = fx;
      ty = fy;
    end else if (r < 50) begin
      tx = clamp_coord(fx + int'($urandom_range(4000)) - 2000);
      ty = clamp_coord(fy + int'($urandom_range(4000)) - 2000);
    end else if (r < 72) begin
      tx = $urandom_range(65535);
      ty = $urandom_range(65535);
    end else if (r < 96) begin
      tx = clamp_coord(fx + (int'($urandom_range(2)) - 1) * d);
      ty = clamp_coord(fy + (int'($urandom_range(2)) - 1) * d);
    end else begin
      tx = (fx < 32768) ? 65535 : 0;
      ty = fy;
    end
  endtask

  // Send one touch event; idle first at the current rate, then hold until accepted
  task automatic send_event(input logic [OP_W-1:0] op, input int slot, input int x, input int y);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, COORD_W'(y), COORD_W'(x), SLOT_W'(slot)};
    do @(posedge clk); while (!in_tready);
    n_events++;
    if ((op <= OP_MOTION && slot < TGC_SLOT_COUNT) || op == OP_EVAL) n_live++;
    if (op == OP_DOWN && slot < TGC_SLOT_COUNT) held[slot] = 1'b1;
    else if (op == OP_UP && slot < TGC_SLOT_COUNT) held[slot] = 1'b0;
  endtask

  // Any opcode, any slot, any position: covers ignored and stray events
  task automatic send_noise();
    send_event(OP_W'($urandom_range(7)), $urandom_range(15), $urandom_range(65535),
               $urandom_range(65535));
  endtask

  // Drop valid and hold until every predicted result has come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write all five limit registers back to back; drop valid only after the last
  task automatic program_regs(input logic [COORD_W-1:0] vals [5]);
    logic [REG_W-1:0] idx [5];
    idx = '{REG_EDGE_LEFT, REG_EDGE_RIGHT, REG_EDGE_TOP, REG_EDGE_BOTTOM, REG_MIN_TRAVEL};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      n_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // One well-formed gesture: fingers down, moves, fingers up, evaluate.
  // Fewer fingers are far more common; now and then all slots take part.
  task automatic run_gesture();
    int pick [TGC_SLOT_COUNT];
    int px [TGC_SLOT_COUNT];
    int py [TGC_SLOT_COUNT];
    int nf, r, j, tmp, nx, ny;
    for (int i = 0; i < TGC_SLOT_COUNT; i++) pick[i] = i;
    for (int i = TGC_SLOT_COUNT - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = pick[i];
      pick[i] = pick[j];
      pick[j] = tmp;
    end
    r = $urandom_range(99);
    if (r < 45) nf = 1;
    else if (r < 75) nf = 2;
    else if (r < 90) nf = 3;
    else if (r < 96) nf = $urandom_range(TGC_SLOT_COUNT - 1, 4);
    else nf = TGC_SLOT_COUNT;
    for (int k = 0; k < nf; k++) begin
      px[k] = pick_coord();
      py[k] = pick_coord();
      send_event(OP_DOWN, pick[k], px[k], py[k]);
    end
    // a stray event in the middle breaks some sequences
    if ($urandom_range(99) < 10) send_noise();
    for (int k = 0; k < nf; k++) begin
      repeat ($urandom_range(2)) begin
        pick_motion(px[k], py[k], nx, ny);
        px[k] = nx;
        py[k] = ny;
        send_event(OP_MOTION, pick[k], px[k], py[k]);
      end
    end
    for (int k = 0; k < nf; k++)
      send_event(OP_UP, pick[k], $urandom_range(65535), $urandom_range(65535));
    // usually release fingers left down by noise; otherwise evaluate is skipped
    if ($urandom_range(99) < 85) begin
      for (int s = 0; s < TGC_SLOT_COUNT; s++)
        if (held[s]) send_event(OP_UP, s, $urandom_range(65535), $urandom_range(65535));
    end
    send_event(OP_EVAL, $urandom_range(15), $urandom_range(65535), $urandom_range(65535));
    if ($urandom_range(99) < 5)
      send_event(OP_EVAL, $urandom_range(15), $urandom_range(65535), $urandom_range(65535));
  endtask

  initial begin
    logic [COORD_W-1:0] lim [5];
    int seg_start;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events under the reset limits.
    // Evaluate with nothing ready, cancel and a spare opcode, slots out of range.
    send_event(OP_EVAL, 0, 0, 0);
    send_event(OP_CANCEL, 0, 65535, 65535);
    send_event(OP_SPARE_HI, 15, 65535, 0);
    send_event(OP_DOWN, 15, 1234, 4321);
    send_event(OP_MOTION, 10, 65535, 65535);
    // Tap, with an evaluate while the finger is still down
    send_event(OP_DOWN, 3, 100, 100);
    send_event(OP_EVAL, 3, 0, 0);
    send_event(OP_UP, 3, 0, 0);
    send_event(OP_EVAL, 0, 0, 0);
    // Swipe from the left border
    send_event(OP_DOWN, 0, 0, 30000);
    send_event(OP_MOTION, 0, 5000, 30000);
    send_event(OP_UP, 0, 0, 0);
    send_event(OP_EVAL, 0, 0, 0);
    // Single swipe shorter than the minimum travel
    send_event(OP_DOWN, 9, 65535, 65535);
    send_event(OP_MOTION, 9, 65435, 65535);
    send_event(OP_UP, 9, 65535, 65535);
    send_event(OP_EVAL, 9, 65535, 65535);
    // Two fingers moving up together
    send_event(OP_DOWN, 1, 1000, 1000);
    send_event(OP_DOWN, 2, 2000, 1000);
    send_event(OP_MOTION, 1, 1000, 0);
    send_event(OP_MOTION, 2, 2000, 0);
    send_event(OP_UP, 1, 0, 0);
    send_event(OP_UP, 2, 0, 0);
    send_event(OP_EVAL, 0, 0, 0);
    // Motion and up on slots that were never put down
    send_event(OP_MOTION, 5, 300, 65535);
    send_event(OP_UP, 4, 0, 0);
    send_event(OP_UP, 5, 0, 0);
    send_event(OP_EVAL, 0, 0, 0);

    // Random part: one limit setting and one idle/stall mix per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0: lim = '{RST_EDGE_LEFT, RST_EDGE_RIGHT, RST_EDGE_TOP, RST_EDGE_BOTTOM, RST_MIN_TRAVEL};
        1: lim = '{default: 16'hFFFF};
        2: lim = '{default: 16'h0000};
        3: lim = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd16};
        default: begin
          lim[0] = COORD_W'($urandom_range(4000));
          lim[1] = COORD_W'($urandom_range(65535, 61535));
          lim[2] = COORD_W'($urandom_range(4000));
          lim[3] = COORD_W'($urandom_range(65535, 61535));
          lim[4] = ($urandom_range(99) < 20) ? COORD_W'($urandom_range(65535))
                                             : COORD_W'($urandom_range(3000));
        end
      endcase
      program_regs(lim);
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      seg_start = n_live;
      while (n_live - seg_start < SEG_EVENTS) begin
        if ($urandom_range(99) < 15) send_noise();
        else run_gesture();
      end
    end

    // Drain and let any late beat show up
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d touch events (%0d acted on); predicted %0d gestures, %0d border swipes",
             n_events, n_live, gestures, borders);
    $display("Made %0d register writes over %0d limit settings and four idle/stall mixes",
             n_writes, SEGMENTS);
    if (mismatches == 0 && pending == 0) begin
      $display("touch_gesture_classifier_unit regression: pass");
    end else begin
      $display("touch_gesture_classifier_unit regression: fail");
    end
    $finish;
  end

endmodule
